// ===== rtl/core/dtsc_pkg.sv =====
// Package for the decision-tree stump classifier.
// Holds field widths, mode, status and register codes, the node entry and step result types, and the label mask.
// No dependencies.
package dtsc_pkg;

   // default storage depths handed to the top level
   localparam int DEF_MAX_NODES    = 256;
   localparam int DEF_MAX_FEATURES = 256;

   // fixed by the field widths
   localparam int MAX_LABELS  = 16;
   localparam int VALUE_BITS  = 16;
   localparam int SLOT_W      = 8;
   localparam int CHILD_W     = 8;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int LABEL_CNT_W = 5;
   localparam int NODE_CNT_W  = 9;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 32;

   // item kinds
   localparam logic [MODE_W-1:0] MODE_NODE_WR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FEAT_WR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLASSIFY = 2'd2;

   // result status
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNTRAINED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_WALK  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LABEL_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT  = 1'b1;

   typedef struct packed {
      logic [CHILD_W-1:0]           right;
      logic [CHILD_W-1:0]           left;
      logic [MAX_LABELS-1:0]        signs;
      logic signed [VALUE_BITS-1:0] split;
      logic [SLOT_W-1:0]            feature;
   } node_entry_type;

   localparam int NODE_ENTRY_W = $bits(node_entry_type);

   // outcome of one visit of the compare unit
   typedef struct packed {
      logic                  is_leaf;
      logic                  bad;
      logic [CHILD_W-1:0]    next;
      logic [MAX_LABELS-1:0] signs;
   } step_res_type;

   // bits below the label count
   function automatic logic [MAX_LABELS-1:0] label_mask(input logic [LABEL_CNT_W-1:0] cnt);
      logic [MAX_LABELS-1:0] m;
      m = '0;
      for (int l = 0; l < MAX_LABELS; l++) begin
         m[l] = (32'(l) < 32'(cnt));
      end
      return m;
   endfunction

endpackage

// ===== rtl/core/dtsc_ram.sv =====
// Single write port, single registered read port memory.
// Used for the node table and the feature store; depends on nothing.
module dtsc_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/dtsc_step.sv =====
// Shared compare unit: tests one node's feature against its split.
// Picks the child, flags a bad walk and forms the leaf's label signs; uses dtsc_pkg.
module dtsc_step import dtsc_pkg::*; (
   input  node_entry_type               node,
   input  logic signed [VALUE_BITS-1:0] feat_value,
   input  logic                         feat_oor,
   input  logic [NODE_CNT_W-1:0]        ncount,
   input  logic [NODE_CNT_W-1:0]        steps,
   input  logic [MAX_LABELS-1:0]        lmask,
   output step_res_type                 res
);

   logic signed [VALUE_BITS-1:0] value;
   logic                         phi;
   logic [CHILD_W-1:0]           next;

   // feature index past the store reads zero
   assign value = feat_oor ? '0 : feat_value;
   assign phi   = ($signed(value) >= $signed(node.split));
   assign next  = phi ? node.right : node.left;

   always_comb begin
      res.is_leaf = (node.left == '0);
      res.next    = next;
      res.bad     = !res.is_leaf &&
                    ((steps >= ncount) || ({1'b0, next} >= ncount));
      // label gets +1 when its sign bit equals phi
      res.signs   = ~(node.signs ^ {MAX_LABELS{phi}}) & lmask;
   end

endmodule

// ===== rtl/core/decision_tree_stump_classify.sv =====
// Top level of the decision-tree stump classifier: sequencer, tables, result register.
// Uses dtsc_pkg, dtsc_ram (node table, feature store) and dtsc_step (compare unit).
//
//  channel | dir | handshake             | content
//  req_    | in  | tvalid/tready         | tuser mode, tdata node or feature write fields
//  rsp_    | out | tvalid/tready         | tdata label signs, leaf node, status
//  csr_    | in  | we, no wait           | label_count (0), node_count (1)
//
// Write beats are accepted while idle. A classify beat runs read-node, read-feature and
// compare states for each node visited, leaf included; the final compare loads the result
// register. Each visit is a node-table read, a feature-store read and a pass through the
// compare unit. Untrained trees skip the walk. The input is not ready while a walk runs.
// The result register holds a beat until taken; a walk that ends while it is full waits.
// Reset (synchronous, high) sets label_count 16, node_count 0; tables are not cleared.
module decision_tree_stump_classify import dtsc_pkg::*; #(
   parameter int MAX_NODES    = DEF_MAX_NODES,
   parameter int MAX_FEATURES = DEF_MAX_FEATURES
) (
   input  logic                   clock,
   input  logic                   reset,
   // node_slot, node_feature_sel, node_threshold, node_sign_bits, left_child,
   // right_child, feature_slot, feature_value
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [MODE_W-1:0]      req_tuser,     // mode
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // label_signs, leaf_node, status, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int NIDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int FIDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_RD_NODE   = 3'd1;
   localparam logic [2:0] S_RD_FEAT   = 3'd2;
   localparam logic [2:0] S_CMP       = 3'd3;
   localparam logic [2:0] S_UNTRAINED = 3'd4;

   // input beat fields
   logic [SLOT_W-1:0]     f_node_slot;
   node_entry_type        f_node;
   logic [SLOT_W-1:0]     f_feature_slot;
   logic [VALUE_BITS-1:0] f_feature_value;
   logic [MODE_W-1:0]     f_mode;

   assign f_node_slot     = req_tdata[7:0];
   assign f_node.feature  = req_tdata[15:8];
   assign f_node.split    = req_tdata[31:16];
   assign f_node.signs    = req_tdata[47:32];
   assign f_node.left     = req_tdata[55:48];
   assign f_node.right    = req_tdata[63:56];
   assign f_feature_slot  = req_tdata[71:64];
   assign f_feature_value = req_tdata[87:72];
   assign f_mode          = req_tuser;

   logic [2:0]               state_ff, state_in;
   logic [CHILD_W-1:0]       cur_ff, cur_in;
   logic [NODE_CNT_W-1:0]    steps_ff, steps_in;
   logic [LABEL_CNT_W-1:0]   label_count_ff;
   logic [NODE_CNT_W-1:0]    node_count_ff;
   logic                     feat_oor_ff, feat_oor_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   logic                     accept;
   logic                     node_we;
   logic                     feat_we;
   logic                     out_free;
   logic [NODE_CNT_W-1:0]    ncount;
   logic [MAX_LABELS-1:0]    lmask;
   node_entry_type           node_q;
   logic [NODE_ENTRY_W-1:0]  node_rd;
   logic [VALUE_BITS-1:0]    feat_q;
   step_res_type             step;

   assign accept   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign node_we  = accept && (f_mode == MODE_NODE_WR) && (32'(f_node_slot) < MAX_NODES);
   assign feat_we  = accept && (f_mode == MODE_FEAT_WR) &&
                     (32'(f_feature_slot) < MAX_FEATURES);

   // effective node count, capped at the table depth
   assign ncount = (32'(node_count_ff) > MAX_NODES) ? NODE_CNT_W'(MAX_NODES)
                                                    : node_count_ff;
   assign lmask  = label_mask(label_count_ff);

   // node table, read every cycle at the current node
   dtsc_ram #(
      .DEPTH (MAX_NODES),
      .WIDTH (NODE_ENTRY_W)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (NIDX_W'(f_node_slot)),
      .wr_data (f_node),
      .rd_addr (NIDX_W'(cur_ff)),
      .rd_data (node_rd)
   );

   assign node_q = node_entry_type'(node_rd);

   // feature store, read at the feature the current node tests
   dtsc_ram #(
      .DEPTH (MAX_FEATURES),
      .WIDTH (VALUE_BITS)
   ) u_feat_ram (
      .clock   (clock),
      .wr_en   (feat_we),
      .wr_addr (FIDX_W'(f_feature_slot)),
      .wr_data (f_feature_value),
      .rd_addr (FIDX_W'(node_q.feature)),
      .rd_data (feat_q)
   );

   assign feat_oor_in = (32'(node_q.feature) >= MAX_FEATURES);

   dtsc_step u_step (
      .node       (node_q),
      .feat_value (feat_q),
      .feat_oor   (feat_oor_ff),
      .ncount     (ncount),
      .steps      (steps_ff),
      .lmask      (lmask),
      .res        (step)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (f_mode == MODE_CLASSIFY)) begin
               cur_in   = '0;
               steps_in = '0;
               state_in = (ncount == '0) ? S_UNTRAINED : S_RD_NODE;
            end
         end
         S_RD_NODE: begin
            state_in = S_RD_FEAT;
         end
         S_RD_FEAT: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (step.is_leaf || step.bad) begin
               if (out_free) begin
                  rsp_tvalid_in = 1'b1;
                  rsp_tdata_in  = {6'b0,
                                   step.is_leaf ? ST_OK : ST_BAD_WALK,
                                   cur_ff,
                                   step.is_leaf ? step.signs : '0};
                  state_in      = S_IDLE;
               end
            end else begin
               cur_in   = step.next;
               steps_in = steps_ff + NODE_CNT_W'(1);
               state_in = S_RD_NODE;
            end
         end
         S_UNTRAINED: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {6'b0, ST_UNTRAINED, {CHILD_W{1'b0}}, {MAX_LABELS{1'b0}}};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_tvalid_ff  <= 1'b0;
         label_count_ff <= LABEL_CNT_W'(MAX_LABELS);
         node_count_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_LABEL_COUNT: label_count_ff <= csr_wdata[LABEL_CNT_W-1:0];
               CSR_NODE_COUNT:  node_count_ff  <= csr_wdata;
               default:         node_count_ff  <= node_count_ff;
            endcase
         end
      end
   end

   // walk and payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      steps_ff     <= steps_in;
      feat_oor_ff  <= feat_oor_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // the walk never passes its step budget
   a_steps_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (steps_ff <= ncount))
      else $error("walk step count past node count");

   // the walk only visits nodes inside the tree
   a_cur_in_tree: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> ({1'b0, cur_ff} < ncount) || (state_ff == S_UNTRAINED))
      else $error("walk left the valid nodes");

   // failed walks carry no label signs
   a_fail_no_signs: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[25:24] != ST_OK)) |-> (rsp_tdata[15:0] == '0))
      else $error("label signs on a failed walk");

   // labels past the label count stay clear
   a_label_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[15:0] & ~lmask) == '0))
      else $error("label sign set past label count");

   // untrained answer reports node zero
   a_untrained_leaf: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[25:24] == ST_UNTRAINED)) |-> (rsp_tdata[23:16] == '0))
      else $error("untrained result names a node");

endmodule

// ===== tb/sv/decision_tree_stump_classify_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the decision-tree stump classifier: watches the request,
// result and register ports, walks its own copy of the tree and compares each result beat.
// Depends on dtsc_pkg for widths, mode, status and register codes and the node entry type.
module decision_tree_stump_classify_checker
   import dtsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [MODE_W-1:0]      req_tuser,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   localparam int PAD_W = RSP_TDATA_W - MAX_LABELS - CHILD_W - STATUS_W;

   // result beat as it sits in rsp_tdata, lowest field last
   typedef struct packed {
      logic [PAD_W-1:0]      pad;
      logic [STATUS_W-1:0]   status;
      logic [CHILD_W-1:0]    leaf;
      logic [MAX_LABELS-1:0] signs;
   } rsp_word_type;

   // private copy of the block state
   node_entry_type               node_tab [DEF_MAX_NODES];
   logic signed [VALUE_BITS-1:0] feat_tab [DEF_MAX_FEATURES];
   logic [LABEL_CNT_W-1:0]       label_cnt;
   logic [NODE_CNT_W-1:0]        node_cnt;

   // results owed by the block, oldest first
   rsp_word_type outcome_q [$];

   // features past the store read as zero
   function automatic logic signed [VALUE_BITS-1:0] feature_at(input logic [SLOT_W-1:0] idx);
      if (int'(idx) >= DEF_MAX_FEATURES) return '0;
      return feat_tab[idx];
   endfunction

   // walk from the root to a leaf and form the label signs there
   function automatic rsp_word_type walk_tree();
      rsp_word_type                 res;
      node_entry_type               nd;
      int                           ncount;
      int                           nlab;
      int                           steps;
      logic [CHILD_W-1:0]           cur;
      logic [CHILD_W-1:0]           nxt;
      logic signed [VALUE_BITS-1:0] v;
      logic                         phi;
      res    = '0;
      ncount = (int'(node_cnt) > DEF_MAX_NODES) ? DEF_MAX_NODES : int'(node_cnt);
      nlab   = (int'(label_cnt) > MAX_LABELS) ? MAX_LABELS : int'(label_cnt);
      if (ncount == 0) begin
         res.status = ST_UNTRAINED;
         return res;
      end
      cur        = '0;
      steps      = 0;
      res.status = ST_OK;
      while (node_tab[cur].left != '0) begin
         // cap on the walk length catches loops
         if (steps >= ncount) begin
            res.status = ST_BAD_WALK;
            break;
         end
         steps++;
         nd  = node_tab[cur];
         v   = feature_at(nd.feature);
         nxt = (v >= signed'(nd.split)) ? nd.right : nd.left;
         if (int'(nxt) >= ncount) begin
            res.status = ST_BAD_WALK;
            break;
         end
         cur = nxt;
      end
      res.leaf = cur;
      if (res.status == ST_OK) begin
         // the leaf tests its own feature once more
         nd  = node_tab[cur];
         phi = (feature_at(nd.feature) >= signed'(nd.split));
         for (int l = 0; l < nlab; l++) begin
            if (nd.signs[l] == phi) res.signs[l] = 1'b1;
         end
      end
      return res;
   endfunction

   task automatic flag_beat(input string what, input rsp_word_type exp_w,
                            input rsp_word_type act_w);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t %s: expected signs %h leaf %0d status %0d pad %h",
                  $time, what, exp_w.signs, exp_w.leaf, exp_w.status, exp_w.pad);
         $display("   got signs %h leaf %0d status %0d pad %h",
                  act_w.signs, act_w.leaf, act_w.status, act_w.pad);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type      got;
      rsp_word_type      want;
      node_entry_type    nd;
      logic [SLOT_W-1:0] slot;
      if (reset) begin
         label_cnt = LABEL_CNT_W'(MAX_LABELS);
         node_cnt  = '0;
         outcome_q.delete();
      end else begin
         // result side first, so a beat never meets its own prediction
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (outcome_q.size() == 0) begin
               flag_beat("unexpected result", '0, got);
            end else begin
               want = outcome_q.pop_front();
               if (got.signs !== want.signs || got.leaf !== want.leaf ||
                   got.status !== want.status || got.pad !== want.pad)
                  flag_beat("result mismatch", want, got);
            end
         end
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_LABEL_COUNT: label_cnt = csr_wdata[LABEL_CNT_W-1:0];
               CSR_NODE_COUNT:  node_cnt  = csr_wdata[NODE_CNT_W-1:0];
               default: ;
            endcase
         end
         // request side: table updates or a new prediction
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               MODE_NODE_WR: begin
                  slot       = req_tdata[7:0];
                  nd.feature = req_tdata[15:8];
                  nd.split   = req_tdata[31:16];
                  nd.signs   = req_tdata[47:32];
                  nd.left    = req_tdata[55:48];
                  nd.right   = req_tdata[63:56];
                  if (int'(slot) < DEF_MAX_NODES) node_tab[slot] = nd;
               end
               MODE_FEAT_WR: begin
                  slot = req_tdata[71:64];
                  if (int'(slot) < DEF_MAX_FEATURES) feat_tab[slot] = req_tdata[87:72];
               end
               MODE_CLASSIFY: outcome_q = {outcome_q, walk_tree()};
               default: ;  // unused mode: no effect
            endcase
         end
      end
      pending = outcome_q.size();
   end

endmodule

// ===== tb/sv/decision_tree_stump_classify_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the decision-tree stump classifier: clock, reset, stimulus and verdict.
// Depends on dtsc_pkg, the block itself and decision_tree_stump_classify_checker.
module decision_tree_stump_classify_tb;
   import dtsc_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int STALL_LIMIT  = 5000;  // cycles without any accepted beat
   localparam int RANDOM_BEATS = 1060;
   localparam int TAIL_CYCLES  = 800;   // longest walk plus margin

   typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} rdy_pattern_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   // node_slot, node_feature_sel, node_threshold, node_sign_bits, left_child,
   // right_child, feature_slot, feature_value
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]      req_tuser  = MODE_NODE_WR;  // mode
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // label_signs, leaf_node, status, zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = CSR_LABEL_COUNT;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int              failures;
   int              pending;
   int              idle_cycles = 0;
   int              beats_sent  = 0;
   int              burst_left  = 0;
   int              gap_max     = 3;
   int              rdy_left    = 0;
   rdy_pattern_type rdy_mode    = RDY_ALWAYS;

   decision_tree_stump_classify uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   decision_tree_stump_classify_checker leaf_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (failures),
      .pending    (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side backpressure: a pattern held for a random stretch
   always @(negedge clock) begin
      if (rdy_left == 0) begin
         rdy_mode <= rdy_pattern_type'($urandom_range(0, 3));
         rdy_left <= $urandom_range(40, 400);
      end else begin
         rdy_left <= rdy_left - 1;
      end
      case (rdy_mode)
         RDY_ALWAYS: rsp_tready <= 1'b1;
         RDY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         RDY_SPARSE: rsp_tready <= ($urandom_range(0, 7) == 0);
         default:    rsp_tready <= ~rsp_tready;
      endcase
   end

   // watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic logic [REQ_TDATA_W-1:0] noise_bits();
      logic [95:0] w;
      w = {$urandom, $urandom, $urandom};
      return w[REQ_TDATA_W-1:0];
   endfunction

   // one request beat; called and returns at a falling edge
   task automatic push_beat(input logic [MODE_W-1:0] mode, input logic [REQ_TDATA_W-1:0] data);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tuser  <= mode;
      req_tdata  <= data;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (mode != MODE_UNUSED) beats_sent++;
      @(negedge clock);
   endtask

   task automatic wr_node(input logic [7:0] slot, input logic [7:0] fsel, input logic [15:0] thr,
                          input logic [15:0] signs, input logic [7:0] l, input logic [7:0] r);
      logic [REQ_TDATA_W-1:0] d;
      d        = noise_bits();
      d[7:0]   = slot;
      d[15:8]  = fsel;
      d[31:16] = thr;
      d[47:32] = signs;
      d[55:48] = l;
      d[63:56] = r;
      push_beat(MODE_NODE_WR, d);
   endtask

   task automatic wr_feat(input logic [7:0] slot, input logic [15:0] val);
      logic [REQ_TDATA_W-1:0] d;
      d        = noise_bits();
      d[71:64] = slot;
      d[87:72] = val;
      push_beat(MODE_FEAT_WR, d);
   endtask

   task automatic classify();
      push_beat(MODE_CLASSIFY, noise_bits());
   endtask

   task automatic noise();
      push_beat(MODE_UNUSED, noise_bits());
   endtask

   // stop sending and let every owed result come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // features cluster near a base so rewrites change the walks
   function automatic logic [7:0] pick_feature(input logic [7:0] fbase);
      if ($urandom_range(0, 15) == 0) return 8'($urandom);
      return fbase + 8'($urandom_range(0, 7));
   endfunction

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // one register setting: new counts, a fresh tree, then feature updates and classifies
   task automatic run_phase();
      logic [LABEL_CNT_W-1:0] lc;
      logic [NODE_CNT_W-1:0]  nc;
      logic [7:0]             fbase;
      logic [7:0]             l;
      logic [7:0]             r;
      int                     pick;
      int                     k;
      int                     rounds;
      bit                     broken;
      bit                     leaf;
      drain();
      pick = $urandom_range(0, 5);
      lc   = (pick == 0) ? 5'd1 : (pick == 1) ? 5'd16 : 5'($urandom_range(1, 16));
      pick = $urandom_range(0, 19);
      if (pick == 0)     nc = '0;
      else if (pick == 1) nc = 9'd256;
      else if (pick < 4) nc = 9'($urandom_range(17, 64));
      else               nc = 9'($urandom_range(1, 16));
      csr_write(CSR_LABEL_COUNT, CSR_DATA_W'(lc));
      csr_write(CSR_NODE_COUNT, nc);
      gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = 0;
      broken     = ($urandom_range(0, 4) == 0);
      fbase      = 8'($urandom);
      k          = (int'(nc) > 40) ? $urandom_range(8, 40) : int'(nc);
      // children point forward, so a well-formed tree has no loops
      for (int i = 0; i < k; i++) begin
         leaf = (i == k - 1) || ($urandom_range(0, 9) < 3);
         if (broken && $urandom_range(0, 3) == 0) begin
            l = 8'($urandom);
            r = 8'($urandom);
         end else if (leaf) begin
            l = '0;
            r = 8'($urandom);
         end else begin
            l = 8'($urandom_range(i + 1, k - 1));
            r = 8'($urandom_range(i + 1, k - 1));
         end
         wr_node(8'(i), pick_feature(fbase), pick_value(), 16'($urandom), l, r);
      end
      rounds = (int'(nc) == 256) ? 6 : $urandom_range(6, 16);
      repeat (rounds) begin
         repeat ($urandom_range(0, 4)) wr_feat(pick_feature(fbase), pick_value());
         classify();
         if ($urandom_range(0, 15) == 0) noise();
      end
   endtask

   initial begin
      int first_random;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill every node and feature entry so no walk reads an unwritten one
      for (int i = 0; i < DEF_MAX_NODES; i++) begin
         wr_node(8'(i), 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
         wr_feat(8'(i), 16'($urandom));
      end

      // untrained tree, then an unused mode
      classify();
      noise();
      drain();
      csr_write(CSR_LABEL_COUNT, 9'd16);
      csr_write(CSR_NODE_COUNT, 9'd4);

      // small tree: root, two leaves, a node that loops on itself
      wr_node(8'd0, 8'hFF, 16'h8000, 16'hFFFF, 8'd1, 8'd2);
      wr_node(8'd1, 8'h00, 16'h7FFF, 16'h0000, 8'd0, 8'hFF);
      wr_node(8'd2, 8'h00, 16'h0000, 16'hA5A5, 8'd0, 8'd0);
      wr_node(8'd3, 8'h80, 16'h0000, 16'h5A5A, 8'd3, 8'd3);
      wr_feat(8'hFF, 16'h8000);
      wr_feat(8'h00, 16'h7FFF);
      classify();                          // value equal to split goes right
      wr_feat(8'h00, 16'hFFFF);
      classify();                          // leaf test fails
      wr_node(8'd0, 8'hFF, 16'h7FFF, 16'hFFFF, 8'd1, 8'd2);
      wr_feat(8'hFF, 16'h7FFE);
      classify();                          // left branch
      wr_node(8'd0, 8'hFF, 16'h7FFF, 16'h0000, 8'd1, 8'd200);
      wr_feat(8'hFF, 16'h7FFF);
      classify();                          // child past node count
      wr_node(8'd0, 8'hFF, 16'h8000, 16'h0000, 8'd1, 8'd3);
      classify();                          // walk never reaches a leaf
      wr_node(8'd255, 8'hFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
      drain();
      csr_write(CSR_LABEL_COUNT, 9'd1);
      wr_node(8'd0, 8'hFF, 16'h8000, 16'h0001, 8'd0, 8'd0);
      classify();                          // root is a leaf, one label

      // random phases
      first_random = beats_sent;
      while (beats_sent - first_random < RANDOM_BEATS) run_phase();

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (failures == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
